/* hw/rtl/symmetry_orbit_codebook_match_top_macros.svh */
// ----------------------------------------------------------------------------
// symmetry_orbit_codebook_match_top_macros.svh
// Assertion macros for the codebook match block. They sample on clk and
// are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SYMMETRY_ORBIT_CODEBOOK_MATCH_TOP_MACROS_SVH
`define SYMMETRY_ORBIT_CODEBOOK_MATCH_TOP_MACROS_SVH

// Same-cycle implication
`define SOCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SOCM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/socm_pkg.sv */
// ----------------------------------------------------------------------------
// socm_pkg
// Shared constants and types of the codebook match block.
// ----------------------------------------------------------------------------
package socm_pkg;

    // Default sizes
    localparam int ATOM_CAPACITY_DEF = 128;
    localparam int BLOCK_SIDE_DEF    = 4;

    // Field widths
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 7;
    localparam int POS_W   = 2;
    localparam int VAL_W   = 16;
    localparam int CFG_W   = 8;
    localparam int MORPH_W = 6;
    localparam int SCORE_W = 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ATOM_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TARGET_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH       = 2'd2;

    // Distinct geometric transforms (transpose, row and column reverse)
    localparam int NUM_XFORM = 8;
    // Morphism bit that negates
    localparam int NEG_POS   = 4;

    // Scoring
    localparam int NORM_SHIFT  = 12;
    localparam int DIV_SHIFT   = 26;
    localparam int QUOT_BITS   = 17;
    localparam int SCORE_ONE   = 16384;
    localparam int SCORE_FLOOR = -32768;
    localparam int QMAG_W      = 15;

    // Correlator control
    typedef struct packed {
        logic clear;
        logic valid;
        logic load_target;
    } corr_ctl_t;

endpackage

/* hw/rtl/socm_sqrt.sv */
// ----------------------------------------------------------------------------
// socm_sqrt
// Iterative integer square root of (operand << NORM_SHIFT), one result bit
// per cycle.
// ----------------------------------------------------------------------------
module socm_sqrt
    import socm_pkg::*;
#(
    parameter int SUMW = 35,
    localparam int VW  = SUMW + NORM_SHIFT,
    localparam int RTW = (VW + 1) / 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SUMW-1:0] operand,
    output logic            done,
    output logic [RTW-1:0]  root
);

    localparam int ITW = $clog2(RTW + 1);

    logic [VW-1:0]  v_reg, v_next;
    logic [VW-1:0]  res_reg, res_next;
    logic [VW-1:0]  bit_reg, bit_next;
    logic [ITW-1:0] it_reg, it_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [VW:0]    trial;

    // One step of the digit-by-digit root
    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start)
        begin
            v_next    = {operand, {NORM_SHIFT{1'b0}}};
            res_next  = '0;
            bit_next  = VW'(1) << (2 * (RTW - 1));
            it_next   = ITW'(RTW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next   = v_reg - trial[VW-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            it_next  = it_reg - ITW'(1);
            if (it_reg == ITW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[RTW-1:0];

endmodule

/* hw/rtl/socm_div.sv */
// ----------------------------------------------------------------------------
// socm_div
// Restoring divider, one quotient bit per cycle, all transform lanes in
// step. Gives min(floor(mag * 2^DIV_SHIFT / den), SCORE_ONE).
// ----------------------------------------------------------------------------
module socm_div
    import socm_pkg::*;
#(
    parameter int SUMW = 35,
    parameter int DENW = 48
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [NUM_XFORM-1:0][SUMW-1:0]  mag,
    input  logic [DENW-1:0]                 den,
    output logic                            done,
    output logic [NUM_XFORM-1:0][QMAG_W-1:0] quo
);

    localparam int RW  = DENW + 1;
    localparam int PRE = DIV_SHIFT - QUOT_BITS;
    localparam int XW  = (SUMW + PRE > RW) ? SUMW + PRE : RW;
    localparam int SW  = $clog2(QUOT_BITS + 1);

    logic [RW-1:0]        rem_reg [NUM_XFORM];
    logic [RW-1:0]        rem_next [NUM_XFORM];
    logic [QUOT_BITS-1:0] q_reg [NUM_XFORM];
    logic [QUOT_BITS-1:0] q_next [NUM_XFORM];
    logic [NUM_XFORM-1:0] ovf_reg, ovf_next;
    logic [DENW-1:0]      den_reg, den_next;
    logic [SW-1:0]        step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [XW-1:0] pre_val [NUM_XFORM];
    logic [RW-1:0] shl [NUM_XFORM];

    // Load and iterate every lane
    always_comb
    begin
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        for (int b = 0; b < NUM_XFORM; b++)
        begin
            rem_next[b] = rem_reg[b];
            q_next[b]   = q_reg[b];
            pre_val[b]  = XW'(mag[b]) << PRE;
            shl[b]      = rem_reg[b] << 1;
        end
        if (start)
        begin
            den_next  = den;
            step_next = SW'(QUOT_BITS);
            busy_next = 1'b1;
            for (int b = 0; b < NUM_XFORM; b++)
            begin
                ovf_next[b] = pre_val[b] >= XW'(den);
                rem_next[b] = ovf_next[b] ? '0 : pre_val[b][RW-1:0];
                q_next[b]   = '0;
            end
        end
        else if (busy_reg)
        begin
            for (int b = 0; b < NUM_XFORM; b++)
            begin
                if (shl[b] >= RW'(den_reg))
                begin
                    rem_next[b] = shl[b] - RW'(den_reg);
                    q_next[b]   = {q_reg[b][QUOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[b] = shl[b];
                    q_next[b]   = {q_reg[b][QUOT_BITS-2:0], 1'b0};
                end
            end
            step_next = step_reg - SW'(1);
            if (step_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        ovf_reg <= ovf_next;
        for (int b = 0; b < NUM_XFORM; b++)
        begin
            rem_reg[b] <= rem_next[b];
            q_reg[b]   <= q_next[b];
        end
    end

    // Saturate to one
    always_comb
    begin
        for (int b = 0; b < NUM_XFORM; b++)
        begin
            if (ovf_reg[b] || (q_reg[b] > QUOT_BITS'(SCORE_ONE)))
                quo[b] = QMAG_W'(SCORE_ONE);
            else
                quo[b] = q_reg[b][QMAG_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

/* hw/rtl/socm_corr.sv */
// ----------------------------------------------------------------------------
// socm_corr
// Correlator: holds the target in one permuted ring per transform, and
// accumulates the energy and the eight transform dot products of a
// streamed block.
// ----------------------------------------------------------------------------
module socm_corr
    import socm_pkg::*;
#(
    parameter int BLOCK_SIDE = 4,
    parameter int SUMW       = 35,
    localparam int ELEMS     = BLOCK_SIDE * BLOCK_SIDE,
    localparam int EW        = $clog2(ELEMS),
    localparam int DOTW      = SUMW + 1
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  corr_ctl_t                      ctl,
    input  logic [EW-1:0]                  idx,
    input  logic signed [VAL_W-1:0]        elem,
    output logic [SUMW-1:0]                asum,
    output logic [NUM_XFORM-1:0][DOTW-1:0] dot
);

    localparam int PW = 2 * VAL_W;

    // Atom element index that meets target element p under transform b
    function automatic int xform_pos(input int b, input int p);
        int r;
        int c;
        int t;
        r = p / BLOCK_SIDE;
        c = p % BLOCK_SIDE;
        if ((b & 4) != 0) r = BLOCK_SIDE - 1 - r;
        if ((b & 2) != 0) c = BLOCK_SIDE - 1 - c;
        if ((b & 1) != 0)
        begin
            t = r;
            r = c;
            c = t;
        end
        return r * BLOCK_SIDE + c;
    endfunction

    logic signed [VAL_W-1:0] ring_reg [NUM_XFORM][ELEMS];
    logic signed [PW-1:0]    prod_reg [NUM_XFORM];
    logic [PW-2:0]           sq_reg;
    logic signed [PW-1:0]    sq_full;
    logic                    v1_reg;
    logic [SUMW-1:0]         asum_reg;
    logic signed [DOTW-1:0]  dot_reg [NUM_XFORM];

    assign sq_full = elem * elem;

    // Stage 1: ring load or rotate, products
    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            sq_reg <= sq_full[PW-2:0];
            for (int b = 0; b < NUM_XFORM; b++)
            begin
                prod_reg[b] <= elem * ring_reg[b][0];
                if (ctl.load_target)
                begin
                    for (int p = 0; p < ELEMS; p++)
                    begin
                        if (idx == EW'(p))
                            ring_reg[b][xform_pos(b, p)] <= elem;
                    end
                end
                else
                begin
                    for (int e = 0; e < ELEMS - 1; e++)
                        ring_reg[b][e] <= ring_reg[b][e+1];
                    ring_reg[b][ELEMS-1] <= ring_reg[b][0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= ctl.valid;
    end

    // Stage 2: accumulate
    always_ff @(posedge clk)
    begin
        if (ctl.clear)
        begin
            asum_reg <= '0;
            for (int b = 0; b < NUM_XFORM; b++)
                dot_reg[b] <= '0;
        end
        else if (v1_reg)
        begin
            asum_reg <= asum_reg + SUMW'(sq_reg);
            for (int b = 0; b < NUM_XFORM; b++)
                dot_reg[b] <= dot_reg[b] + DOTW'(prod_reg[b]);
        end
    end

    always_comb
    begin
        for (int b = 0; b < NUM_XFORM; b++)
            dot[b] = dot_reg[b];
    end

    assign asum = asum_reg;

endmodule

/* hw/rtl/symmetry_orbit_codebook_match_top.sv */
// ----------------------------------------------------------------------------
// symmetry_orbit_codebook_match_top
// Codebook search of stored square atoms against a target block under the
// 64 morphism numbers, with element loads and a result per search.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------
//  in       | in        | in_valid / in_ready   | command atom_index row column value
//  out      | out       | out_valid / out_ready | found best_atom best_morphism score
//  cfg      | in        | cfg_valid / cfg_ready | cfg_data (atoms_in_use)
//
// A search sweeps the target; if no atoms are in use or the target is all
// zero it posts an empty result, else it takes the target root and then per
// atom runs the memory sweep and the step to the next atom, plus for a nonzero
// atom a root, a divider start, a divider run over eight lanes and a compare
// of sixteen candidates, then it posts the result. Nothing needs clearing
// after reset. Loads are taken while a result waits on out; a search that
// ends with a result still waiting holds until it is taken. cfg is taken
// only while no search runs.
// ----------------------------------------------------------------------------
`include "symmetry_orbit_codebook_match_top_macros.svh"

module symmetry_orbit_codebook_match_top
    import socm_pkg::*;
#(
    parameter int ATOM_CAPACITY = ATOM_CAPACITY_DEF,
    parameter int BLOCK_SIDE    = BLOCK_SIDE_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CMD_W-1:0]          command,
    input  logic [IDX_W-1:0]          atom_index,
    input  logic [POS_W-1:0]          row,
    input  logic [POS_W-1:0]          column,
    input  logic signed [VAL_W-1:0]   value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      found,
    output logic [IDX_W-1:0]          best_atom,
    output logic [MORPH_W-1:0]        best_morphism,
    output logic signed [SCORE_W-1:0] score,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_W-1:0]          cfg_data
);

    localparam int ELEMS = BLOCK_SIDE * BLOCK_SIDE;
    localparam int EW    = $clog2(ELEMS);
    localparam int AW    = $clog2(ATOM_CAPACITY * ELEMS);
    localparam int CW    = $clog2(ATOM_CAPACITY + 1);
    localparam int CNTW  = $clog2(ELEMS + 3);
    localparam int SUMW  = 2 * VAL_W - 1 + $clog2(ELEMS);
    localparam int DOTW  = SUMW + 1;
    localparam int VW    = SUMW + NORM_SHIFT;
    localparam int RTW   = (VW + 1) / 2;
    localparam int DENW  = 2 * RTW;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TPASS = 4'd1;
    localparam logic [3:0] S_TSQRT = 4'd2;
    localparam logic [3:0] S_APASS = 4'd3;
    localparam logic [3:0] S_ASQRT = 4'd4;
    localparam logic [3:0] S_DIVST = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_NEXT  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]               state_reg, state_next;
    logic [CNTW-1:0]          cnt_reg, cnt_next;
    logic [3:0]               ci_reg, ci_next;
    logic [CW-1:0]            k_reg, k_next;
    logic [RTW-1:0]           nt_reg, nt_next;
    logic [DENW-1:0]          den_reg, den_next;
    logic signed [SCORE_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]         bid_reg, bid_next;
    logic [MORPH_W-1:0]       bm_reg, bm_next;
    logic                     have_reg, have_next;
    logic [CFG_W-1:0]         cfg_reg;
    logic                     out_valid_reg, out_valid_next;
    logic                     found_reg, found_next;
    logic [IDX_W-1:0]         best_atom_reg, best_atom_next;
    logic [MORPH_W-1:0]       best_morphism_reg, best_morphism_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic                     elem_v_reg, elem_v_next;
    logic                     elem_tgt_reg, elem_tgt_next;
    logic [EW-1:0]            elem_idx_reg, elem_idx_next;

    logic signed [VAL_W-1:0]  atom_mem [ATOM_CAPACITY * ELEMS];
    logic signed [VAL_W-1:0]  tgt_mem [ELEMS];
    logic signed [VAL_W-1:0]  atom_rdata_reg;
    logic signed [VAL_W-1:0]  tgt_rdata_reg;

    logic                     accept;
    logic                     wr_pos_ok;
    logic                     atom_we;
    logic                     tgt_we;
    logic [31:0]              atom_waddr_full;
    logic [31:0]              atom_raddr_full;
    logic [31:0]              tgt_waddr_full;
    logic [AW-1:0]            atom_waddr;
    logic [AW-1:0]            atom_raddr;
    logic [EW-1:0]            tgt_waddr;
    logic [EW-1:0]            tgt_raddr;
    logic [CW-1:0]            count;
    logic                     pass_end;

    corr_ctl_t                corr_ctl;
    logic signed [VAL_W-1:0]  elem;
    logic [SUMW-1:0]          asum;
    logic [NUM_XFORM-1:0][DOTW-1:0]   dot;
    logic [NUM_XFORM-1:0][SUMW-1:0]   mag;
    logic [NUM_XFORM-1:0][QMAG_W-1:0] quo;
    logic signed [DOTW-1:0]   dot_s;

    logic                     sqrt_start;
    logic                     sqrt_done;
    logic [RTW-1:0]           sqrt_root;
    logic                     div_start;
    logic                     div_done;

    logic [2:0]               lane;
    logic                     cand_neg;
    logic signed [SCORE_W-1:0] cand_mag;
    logic signed [SCORE_W-1:0] cand;
    logic [MORPH_W-1:0]       cand_m;

    // Request decode
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign wr_pos_ok = (int'(row) < BLOCK_SIDE) && (int'(column) < BLOCK_SIDE);
    assign atom_we   = accept && (command == CMD_ATOM_WRITE) && wr_pos_ok
                       && (int'(atom_index) < ATOM_CAPACITY);
    assign tgt_we    = accept && (command == CMD_TARGET_WRITE) && wr_pos_ok;

    assign atom_waddr_full = 32'(atom_index) * 32'(ELEMS) + 32'(row) * 32'(BLOCK_SIDE)
                             + 32'(column);
    assign tgt_waddr_full  = 32'(row) * 32'(BLOCK_SIDE) + 32'(column);
    assign atom_raddr_full = 32'(k_reg) * 32'(ELEMS) + 32'(cnt_reg);
    assign atom_waddr      = atom_waddr_full[AW-1:0];
    assign atom_raddr      = atom_raddr_full[AW-1:0];
    assign tgt_waddr       = tgt_waddr_full[EW-1:0];
    assign tgt_raddr       = cnt_reg[EW-1:0];

    // Atom memory
    always_ff @(posedge clk)
    begin
        if (atom_we)
            atom_mem[atom_waddr] <= value;
        atom_rdata_reg <= atom_mem[atom_raddr];
    end

    // Target memory
    always_ff @(posedge clk)
    begin
        if (tgt_we)
            tgt_mem[tgt_waddr] <= value;
        tgt_rdata_reg <= tgt_mem[tgt_raddr];
    end

    // Configuration register, written only between searches
    assign cfg_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid && cfg_ready)
            cfg_reg <= cfg_data;
    end

    assign count = (int'(cfg_reg) > ATOM_CAPACITY) ? CW'(ATOM_CAPACITY) : CW'(cfg_reg);

    // Correlator feed
    assign corr_ctl.clear       = ((state_reg == S_TPASS) || (state_reg == S_APASS))
                                  && (cnt_reg == '0);
    assign corr_ctl.valid       = elem_v_reg;
    assign corr_ctl.load_target = elem_tgt_reg;
    assign elem                 = elem_tgt_reg ? tgt_rdata_reg : atom_rdata_reg;

    socm_corr #(
        .BLOCK_SIDE (BLOCK_SIDE),
        .SUMW       (SUMW)
    ) u_corr (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (corr_ctl),
        .idx   (elem_idx_reg),
        .elem  (elem),
        .asum  (asum),
        .dot   (dot)
    );

    // Magnitudes of the dot products
    always_comb
    begin
        dot_s = '0;
        for (int b = 0; b < NUM_XFORM; b++)
        begin
            dot_s  = $signed(dot[b]);
            mag[b] = dot_s[DOTW-1] ? SUMW'(-dot_s) : SUMW'(dot_s);
        end
    end

    assign pass_end   = (cnt_reg == CNTW'(ELEMS + 2));
    assign sqrt_start = pass_end && (asum != '0)
                        && (((state_reg == S_TPASS) && (count != '0))
                            || (state_reg == S_APASS));
    assign div_start  = (state_reg == S_DIVST);

    socm_sqrt #(
        .SUMW (SUMW)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (asum),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    socm_div #(
        .SUMW (SUMW),
        .DENW (DENW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (mag),
        .den   (den_reg),
        .done  (div_done),
        .quo   (quo)
    );

    // Candidate under compare: lane sign, then negated half
    assign lane     = ci_reg[2:0];
    assign cand_neg = dot[lane][DOTW-1] ^ ci_reg[3];
    assign cand_mag = SCORE_W'(quo[lane]);
    assign cand     = cand_neg ? -cand_mag : cand_mag;

    always_comb
    begin
        cand_m          = '0;
        cand_m[2:0]     = lane;
        cand_m[NEG_POS] = ci_reg[3];
    end

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        ci_next            = ci_reg;
        k_next             = k_reg;
        nt_next            = nt_reg;
        den_next           = den_reg;
        best_next          = best_reg;
        bid_next           = bid_reg;
        bm_next            = bm_reg;
        have_next          = have_reg;
        found_next         = found_reg;
        best_atom_next     = best_atom_reg;
        best_morphism_next = best_morphism_reg;
        score_next         = score_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        elem_v_next        = 1'b0;
        elem_tgt_next      = elem_tgt_reg;
        elem_idx_next      = cnt_reg[EW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (command == CMD_SEARCH))
                begin
                    state_next = S_TPASS;
                    cnt_next   = '0;
                    best_next  = SCORE_W'(SCORE_FLOOR);
                    bid_next   = '0;
                    bm_next    = '0;
                    have_next  = 1'b0;
                end
            end
            S_TPASS:
            begin
                elem_v_next   = (int'(cnt_reg) < ELEMS);
                elem_tgt_next = 1'b1;
                cnt_next      = cnt_reg + CNTW'(1);
                if (pass_end)
                begin
                    if ((count == '0) || (asum == '0))
                        state_next = S_DONE;
                    else
                        state_next = S_TSQRT;
                end
            end
            S_TSQRT:
            begin
                if (sqrt_done)
                begin
                    nt_next    = sqrt_root;
                    k_next     = '0;
                    cnt_next   = '0;
                    state_next = S_APASS;
                end
            end
            S_APASS:
            begin
                elem_v_next   = (int'(cnt_reg) < ELEMS);
                elem_tgt_next = 1'b0;
                cnt_next      = cnt_reg + CNTW'(1);
                if (pass_end)
                begin
                    if (asum == '0)
                        state_next = S_NEXT;
                    else
                        state_next = S_ASQRT;
                end
            end
            S_ASQRT:
            begin
                if (sqrt_done)
                begin
                    den_next   = DENW'(sqrt_root * nt_reg);
                    state_next = S_DIVST;
                end
            end
            S_DIVST:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    ci_next    = '0;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (cand > best_reg)
                begin
                    best_next = cand;
                    bid_next  = IDX_W'(k_reg);
                    bm_next   = cand_m;
                    have_next = 1'b1;
                end
                ci_next = ci_reg + 4'd1;
                if (ci_reg == 4'd15)
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                k_next   = k_reg + CW'(1);
                cnt_next = '0;
                if ((k_reg + CW'(1)) == count)
                    state_next = S_DONE;
                else
                    state_next = S_APASS;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    found_next         = have_reg;
                    best_atom_next     = have_reg ? bid_reg : '0;
                    best_morphism_next = have_reg ? bm_reg : '0;
                    score_next         = have_reg ? best_reg : '0;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ci_reg        <= '0;
            k_reg         <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            elem_v_reg    <= 1'b0;
            elem_tgt_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ci_reg        <= ci_next;
            k_reg         <= k_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
            elem_v_reg    <= elem_v_next;
            elem_tgt_reg  <= elem_tgt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        nt_reg            <= nt_next;
        den_reg           <= den_next;
        best_reg          <= best_next;
        bid_reg           <= bid_next;
        bm_reg            <= bm_next;
        found_reg         <= found_next;
        best_atom_reg     <= best_atom_next;
        best_morphism_reg <= best_morphism_next;
        score_reg         <= score_next;
        elem_idx_reg      <= elem_idx_next;
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign best_atom     = best_atom_reg;
    assign best_morphism = best_morphism_reg;
    assign score         = score_reg;

    // Checks
    `SOCM_ASSERT_NXT(a_search_holds_input, accept && (command == CMD_SEARCH), !in_ready, "search request did not close the input")
    `SOCM_ASSERT_IMP(a_empty_result, out_valid && !found, (best_atom == '0) && (best_morphism == '0) && (score == '0), "empty result carries nonzero fields")
    `SOCM_ASSERT_IMP(a_score_range, out_valid && found, (score <= 16'sd16384) && (score >= -16'sd16384) && !best_morphism[3] && !best_morphism[5], "result out of range")

endmodule

/* tb/tb_symmetry_orbit_codebook_match_top.sv */
// ----------------------------------------------------------------------------
// tb_symmetry_orbit_codebook_match_top
// Self-checking bench for the codebook match block. Atom and target loads,
// idle commands and searches go in over a valid/ready channel. A scoreboard
// class keeps its own copy of both stores and of the atom count, predicts
// each search result and checks the output channel in order. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_symmetry_orbit_codebook_match_top;
    import socm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ATOMS  = ATOM_CAPACITY_DEF;
    localparam int SIDE       = BLOCK_SIDE_DEF;
    localparam int ELEMS      = SIDE * SIDE;
    localparam int IDLE_LIMIT = 200000;
    localparam int LOAD_DRAIN = 30;
    localparam int HOLD_LEN   = 1500;
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic                      found;
        logic [IDX_W-1:0]          atom;
        logic [MORPH_W-1:0]        morph;
        logic signed [SCORE_W-1:0] score;
    } match_t;

    // ------------------------------------------------------------------------
    // Scoreboard: store copies, search prediction, in-order compare
    // ------------------------------------------------------------------------
    class match_scoreboard;
        logic signed [VAL_W-1:0] atoms [NUM_ATOMS][ELEMS];
        logic signed [VAL_W-1:0] target [ELEMS];
        int unsigned             atoms_used;
        match_t                  pending_matches [$];
        int                      mismatches;
        int                      results_seen;

        function new();
            foreach (atoms[k, e]) atoms[k][e] = '0;
            foreach (target[e]) target[e] = '0;
            atoms_used   = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_count(logic [CFG_W-1:0] v);
            atoms_used = v;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // Exhaustive search over atoms in use and all 64 morphism numbers
        function match_t best_match();
            match_t          r;
            int unsigned     cnt;
            longint unsigned tsum, nt, asum, na, den, mag, q;
            longint          dot, s, best;
            int              rr, cc, t;
            bit              have;
            r = '0;
            best = SCORE_FLOOR;
            have = 0;
            cnt = (atoms_used > NUM_ATOMS) ? NUM_ATOMS : atoms_used;
            tsum = 0;
            for (int e = 0; e < ELEMS; e++)
                tsum += longint'(target[e]) * longint'(target[e]);
            if (cnt != 0 && tsum != 0) begin
                nt = int_sqrt(tsum << NORM_SHIFT);
                for (int k = 0; k < cnt; k++) begin
                    asum = 0;
                    for (int e = 0; e < ELEMS; e++)
                        asum += longint'(atoms[k][e]) * longint'(atoms[k][e]);
                    if (asum == 0) continue;   // zero atom is skipped
                    na  = int_sqrt(asum << NORM_SHIFT);
                    den = na * nt;
                    for (int m = 0; m < 64; m++) begin
                        dot = 0;
                        for (int i = 0; i < SIDE; i++)
                            for (int j = 0; j < SIDE; j++) begin
                                rr = i;
                                cc = j;
                                if (m & 4) rr = SIDE - 1 - rr;
                                if (m & 2) cc = SIDE - 1 - cc;
                                if (m & 1) begin t = rr; rr = cc; cc = t; end
                                dot += longint'(atoms[k][rr*SIDE+cc])
                                     * longint'(target[i*SIDE+j]);
                            end
                        if (m & (1 << NEG_POS)) dot = -dot;
                        mag = (dot < 0) ? longint'(-dot) : dot;
                        q = (mag << DIV_SHIFT) / den;
                        if (q > SCORE_ONE) q = SCORE_ONE;
                        s = (dot < 0) ? -longint'(q) : longint'(q);
                        // strictly greater: earliest candidate keeps ties
                        if (s > best) begin
                            best = s;
                            r.atom  = k[IDX_W-1:0];
                            r.morph = m[MORPH_W-1:0];
                            have = 1;
                        end
                    end
                end
            end
            if (have) begin
                r.found = 1'b1;
                r.score = best[SCORE_W-1:0];
            end
            else
                r = '0;
            return r;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                   logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                                   logic signed [VAL_W-1:0] v);
            case (cmd)
                CMD_ATOM_WRITE:   atoms[idx][r*SIDE+c] = v;
                CMD_TARGET_WRITE: target[r*SIDE+c] = v;
                CMD_SEARCH:       pending_matches.insert(pending_matches.size(),
                                                         best_match());
                default: ;
            endcase
        endfunction

        function void check_result(match_t got);
            match_t exp_m;
            results_seen++;
            if (pending_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result found=%0d atom=%0d morph=%0d score=%0d",
                             got.found, got.atom, got.morph, got.score);
                return;
            end
            exp_m = pending_matches.pop_front();
            if (got.found !== exp_m.found || got.atom !== exp_m.atom ||
                got.morph !== exp_m.morph || got.score !== exp_m.score) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d exp found=%0d atom=%0d morph=%0d score=%0d, got found=%0d atom=%0d morph=%0d score=%0d",
                             results_seen, exp_m.found, exp_m.atom, exp_m.morph,
                             exp_m.score, got.found, got.atom, got.morph, got.score);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [CMD_W-1:0]          command;
    logic [IDX_W-1:0]          atom_index;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          column;
    logic signed [VAL_W-1:0]   value;
    logic                      out_valid;
    logic                      out_ready;
    logic                      found;
    logic [IDX_W-1:0]          best_atom;
    logic [MORPH_W-1:0]        best_morphism;
    logic signed [SCORE_W-1:0] score;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_W-1:0]          cfg_data;

    symmetry_orbit_codebook_match_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .atom_index    (atom_index),
        .row           (row),
        .column        (column),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .best_atom     (best_atom),
        .best_morphism (best_morphism),
        .score         (score),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    match_scoreboard sb = new();

    bit atom_loaded [NUM_ATOMS];
    bit no_idle;
    bit hold_out;
    int items_sent;

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Gap length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_req(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                            logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                            logic signed [VAL_W-1:0] v);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        atom_index <= idx;
        row        <= r;
        column     <= c;
        value      <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(cmd, idx, r, c, v);
        if (cmd != CMD_NOP) items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_matches.size() != 0) @(posedge clk);
        repeat (LOAD_DRAIN) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.set_count(v);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [VAL_W-1:0] rand_val(int kind);
        case (kind)
            0:       return '0;
            1:       return VAL_W'($urandom());
            2:       return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            default: return VAL_W'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
    endfunction

    // kind: 0 zero, 1 full range, 2 extremes, 3 span of +-1.0 in Q1.14, 4 copy of atom 0
    task automatic load_atom(int k, int kind);
        logic signed [VAL_W-1:0] v;
        for (int e = 0; e < ELEMS; e++) begin
            if (kind == 4) v = sb.atoms[0][e];
            else v = rand_val(kind);
            send_req(CMD_ATOM_WRITE, k[IDX_W-1:0], e / SIDE, e % SIDE, v);
        end
        atom_loaded[k] = 1'b1;
    endtask

    task automatic load_target(int kind);
        for (int e = 0; e < ELEMS; e++)
            send_req(CMD_TARGET_WRITE, $urandom(), e / SIDE, e % SIDE, rand_val(kind));
    endtask

    function automatic int atom_kind(int k);
        int r;
        r = $urandom_range(0, 99);
        if (k >= 8 && r < 85) return 0;
        if (r < 15) return 0;
        if (r < 50) return 1;
        if (r < 60) return 2;
        if (r < 85 || !atom_loaded[0]) return 3;
        return 4;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls, one long hold on request
    // ------------------------------------------------------------------------
    initial begin
        int g;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result({found, best_atom, best_morphism, score});
            if (hold_out) begin
                out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_out = 1'b0;
                out_ready <= 1'b1;
            end
            else begin
                g = gap_len();
                if (g > 0) begin
                    out_ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no handshake on any channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("** symmetry_orbit_codebook_match_top: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int v;
        int cnt;
        int ops;
        int r;
        int fixed_counts [4] = '{1, 2, 4, 0};

        rst_n      = 1'b0;
        in_valid   <= 1'b0;
        command    <= CMD_ATOM_WRITE;
        atom_index <= '0;
        row        <= '0;
        column     <= '0;
        value      <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        no_idle    = 1'b0;
        hold_out   = 1'b0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme target, no atoms, search, idle command with extreme fields
        write_cfg(8'd0);
        load_target(2);
        send_req(CMD_SEARCH, '0, '0, '0, '0);
        send_req(CMD_NOP, 7'h7F, 2'd3, 2'd3, 16'sh7FFF);
        drain();

        phase = 0;
        while (items_sent < 290) begin
            if (phase < 4) v = fixed_counts[phase];
            else begin
                r = $urandom_range(0, 9);
                v = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(5, 8);
            end
            cnt = (v > NUM_ATOMS) ? NUM_ATOMS : v;
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < cnt; k++)
                if (!atom_loaded[k]) load_atom(k, atom_kind(k));
            // second phase: second atom takes a copy of the first, then the first is zeroed (skip)
            if (phase == 1) begin
                load_atom(1, 4);
                load_atom(0, 0);
            end
            drain();
            write_cfg(v[CFG_W-1:0]);

            // receiver holds off while several searches pile up
            if (phase == 0) begin
                hold_out = 1'b1;
                for (int i = 0; i < 4; i++) send_req(CMD_SEARCH, '0, '0, '0, '0);
            end

            ops = (cnt >= NUM_ATOMS) ? 3 : $urandom_range(6, 14);
            for (int i = 0; i < ops; i++) begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    send_req(CMD_SEARCH, $urandom(), $urandom(), $urandom(),
                             VAL_W'($urandom()));
                else if (r < 70 && cnt > 0)
                    send_req(CMD_ATOM_WRITE, $urandom_range(0, cnt - 1), $urandom(),
                             $urandom(), rand_val($urandom_range(0, 3)));
                else if (r < 80)
                    send_req(CMD_TARGET_WRITE, $urandom(), $urandom(), $urandom(),
                             rand_val($urandom_range(1, 3)));
                else if (r < 85)
                    send_req(CMD_NOP, $urandom(), $urandom(), $urandom(),
                             VAL_W'($urandom()));
                else if (r < 95)
                    load_target(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3));
                else if (cnt > 0)
                    load_atom($urandom_range(0, cnt - 1), atom_kind(0));
            end
            send_req(CMD_SEARCH, '0, '0, '0, '0);
            drain();
            phase++;
        end

        drain();
        while (hold_out) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_matches.size() == 0)
            $display("** symmetry_orbit_codebook_match_top: PASSED **");
        else
            $display("** symmetry_orbit_codebook_match_top: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/socm_pkg.sv
hw/rtl/socm_sqrt.sv
hw/rtl/socm_div.sv
hw/rtl/socm_corr.sv
hw/rtl/symmetry_orbit_codebook_match_top.sv
tb/tb_symmetry_orbit_codebook_match_top.sv
